[hw/rtl/heartbeat_failover_task_manager_top_macros.svh]
// Assertion macros for the heartbeat failover task manager.
// Expects clk and arst_n in the scope of use; no other dependencies.
`ifndef HEARTBEAT_FAILOVER_TASK_MANAGER_TOP_MACROS_SVH
`define HEARTBEAT_FAILOVER_TASK_MANAGER_TOP_MACROS_SVH

// same-cycle implication
`define HFTM_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define HFTM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/hftm_pkg.sv]
// Shared types and constants of the heartbeat failover task manager.
// No dependencies.
package hftm_pkg;

	localparam int NODES  = 4;
	localparam int TASKS  = 3;
	localparam int NODE_W = 2;
	localparam int TASK_W = 2;
	localparam int TGT_W  = 3;
	localparam int AGE_W  = 16;
	localparam int LOAD_W = 14;

	localparam logic [TASK_W-1:0] NO_TASK = TASK_W'(TASKS);
	localparam logic [TGT_W-1:0]  NO_NODE = TGT_W'(NODES);
	localparam logic [AGE_W-1:0]  AGE_MAX = '1;

	localparam logic [AGE_W-1:0]  TIMEOUT_RST   = 16'd3000;
	localparam logic [LOAD_W-1:0] THRESHOLD_RST = 14'd8000;

	typedef enum logic [2:0] {
		EV_DONE         = 3'd0,
		EV_RECOVERED    = 3'd1,
		EV_FAIL_MOVED   = 3'd2,
		EV_FAIL_NOSPARE = 3'd3,
		EV_FAIL_IDLE    = 3'd4,
		EV_OVL_MOVED    = 3'd5,
		EV_OVL_NOSPARE  = 3'd6
	} hftm_event_t;

	typedef enum logic {
		REQ_HEARTBEAT = 1'b0,
		REQ_TICK      = 1'b1
	} hftm_req_t;

	typedef enum logic {
		REG_TIMEOUT   = 1'b0,
		REG_THRESHOLD = 1'b1
	} hftm_reg_t;

	typedef struct packed {
		logic capture;
		logic apply;
		logic fail_step;
		logic ovl_step;
		logic emit_done;
		logic idx_clr;
	} hftm_cmd_t;

	typedef struct packed {
		logic idx_last;
	} hftm_stat_t;

endpackage

[hw/rtl/hftm_ctrl.sv]
// Sequencer: item update, failure pass, overload pass, closing word.
// Depends on hftm_pkg.
module hftm_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	output hftm_pkg::hftm_cmd_t   cmd,
	input  hftm_pkg::hftm_stat_t  stat
);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_UPDATE = 5'b00010,
		ST_FAIL   = 5'b00100,
		ST_OVL    = 5'b01000,
		ST_DONE   = 5'b10000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					state_d     = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				cmd.apply   = 1'b1;
				cmd.idx_clr = 1'b1;
				state_d     = ST_FAIL;
			end
			ST_FAIL: begin
				cmd.fail_step = 1'b1;
				if (stat.idx_last) begin
					cmd.idx_clr = 1'b1;
					state_d     = ST_OVL;
				end
			end
			ST_OVL: begin
				cmd.ovl_step = 1'b1;
				if (stat.idx_last) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				cmd.emit_done = 1'b1;
				state_d       = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);

endmodule

[hw/rtl/hftm_dp.sv]
// Datapath: node health table, task map, spare search and result word register.
// Depends on hftm_pkg; driven by hftm_ctrl commands.
module hftm_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  hftm_pkg::hftm_cmd_t                cmd,
	output hftm_pkg::hftm_stat_t               stat,
	input  logic                               req_type,
	input  logic [hftm_pkg::NODE_W-1:0]        node_id,
	input  logic [hftm_pkg::LOAD_W-1:0]        cpu_load,
	input  logic [hftm_pkg::AGE_W-1:0]         timeout,
	input  logic [hftm_pkg::LOAD_W-1:0]        threshold,
	output logic                               ev_valid,
	output hftm_pkg::hftm_event_t              ev_code,
	output logic [hftm_pkg::NODE_W-1:0]        ev_node,
	output logic [hftm_pkg::TASK_W-1:0]        ev_task,
	output logic [hftm_pkg::TGT_W-1:0]         ev_target,
	output logic                               ev_last
);

	// latched item
	hftm_pkg::hftm_req_t               req_q;
	logic [hftm_pkg::NODE_W-1:0]       id_q;
	logic [hftm_pkg::LOAD_W-1:0]       load_in_q;

	// node table
	logic [hftm_pkg::AGE_W-1:0]        age_q     [hftm_pkg::NODES];
	logic [hftm_pkg::LOAD_W-1:0]       load_q    [hftm_pkg::NODES];
	logic [hftm_pkg::TASK_W-1:0]       ntask_q   [hftm_pkg::NODES];
	logic [hftm_pkg::NODES-1:0]        seen_q, healthy_q, latch_q;
	logic [hftm_pkg::TGT_W-1:0]        owner_q   [hftm_pkg::TASKS];
	logic [hftm_pkg::NODE_W-1:0]       idx_q;

	// spare search and owner lookup
	logic                              spare_ok;
	logic [hftm_pkg::NODE_W-1:0]       spare_idx;
	logic                              own_ok;
	logic [hftm_pkg::TASK_W-1:0]       own_task;
	logic                              fail_hit, ovl_hit;

	always_comb begin
		spare_ok  = 1'b0;
		spare_idx = '0;
		for (int i = hftm_pkg::NODES - 1; i >= 0; i--) begin
			if (healthy_q[i] && (load_q[i] < threshold) && (ntask_q[i] == hftm_pkg::NO_TASK)) begin
				spare_ok  = 1'b1;
				spare_idx = hftm_pkg::NODE_W'(i);
			end
		end
	end

	// first task owned by the node under inspection
	always_comb begin
		own_ok   = 1'b0;
		own_task = '0;
		for (int j = hftm_pkg::TASKS - 1; j >= 0; j--) begin
			if (owner_q[j] == hftm_pkg::TGT_W'(idx_q)) begin
				own_ok   = 1'b1;
				own_task = hftm_pkg::TASK_W'(j);
			end
		end
	end

	assign fail_hit = seen_q[idx_q] && healthy_q[idx_q] && (age_q[idx_q] > timeout);
	assign ovl_hit  = healthy_q[idx_q] && (load_q[idx_q] >= threshold) && !latch_q[idx_q];
	assign stat.idx_last = (idx_q == hftm_pkg::NODE_W'(hftm_pkg::NODES - 1));

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q     <= hftm_pkg::hftm_req_t'(req_type);
			id_q      <= node_id;
			load_in_q <= cpu_load;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < hftm_pkg::NODES; i++) begin
				age_q[i]   <= '0;
				load_q[i]  <= '0;
				ntask_q[i] <= (i < hftm_pkg::TASKS) ? hftm_pkg::TASK_W'(i) : hftm_pkg::NO_TASK;
			end
			for (int j = 0; j < hftm_pkg::TASKS; j++) begin
				owner_q[j] <= (j < hftm_pkg::NODES) ? hftm_pkg::TGT_W'(j) : hftm_pkg::NO_NODE;
			end
			seen_q    <= '0;
			healthy_q <= '1;
			latch_q   <= '0;
			idx_q     <= '0;
			ev_valid  <= 1'b0;
			ev_code   <= hftm_pkg::EV_DONE;
			ev_node   <= '0;
			ev_task   <= hftm_pkg::NO_TASK;
			ev_target <= hftm_pkg::NO_NODE;
			ev_last   <= 1'b0;
		end else begin
			ev_valid <= 1'b0;

			if (cmd.idx_clr) begin
				idx_q <= '0;
			end else if (cmd.fail_step || cmd.ovl_step) begin
				idx_q <= idx_q + 1'b1;
			end

			if (cmd.apply) begin
				if (req_q == hftm_pkg::REQ_HEARTBEAT) begin
					age_q[id_q]     <= '0;
					seen_q[id_q]    <= 1'b1;
					load_q[id_q]    <= load_in_q;
					healthy_q[id_q] <= 1'b1;
					if (load_in_q < threshold) begin
						latch_q[id_q] <= 1'b0;
					end
					if (!healthy_q[id_q]) begin
						ev_valid  <= 1'b1;
						ev_code   <= hftm_pkg::EV_RECOVERED;
						ev_node   <= id_q;
						ev_task   <= hftm_pkg::NO_TASK;
						ev_target <= hftm_pkg::NO_NODE;
						ev_last   <= 1'b0;
					end
				end else begin
					for (int i = 0; i < hftm_pkg::NODES; i++) begin
						if (seen_q[i] && (age_q[i] != hftm_pkg::AGE_MAX)) begin
							age_q[i] <= age_q[i] + 1'b1;
						end
					end
				end
			end

			if (cmd.fail_step && fail_hit) begin
				healthy_q[idx_q] <= 1'b0;
				ev_valid <= 1'b1;
				ev_node  <= idx_q;
				ev_last  <= 1'b0;
				if (ntask_q[idx_q] != hftm_pkg::NO_TASK) begin
					ev_task <= ntask_q[idx_q];
					if (spare_ok) begin
						ntask_q[idx_q]            <= hftm_pkg::NO_TASK;
						ntask_q[spare_idx]        <= ntask_q[idx_q];
						owner_q[ntask_q[idx_q]]   <= hftm_pkg::TGT_W'(spare_idx);
						ev_code   <= hftm_pkg::EV_FAIL_MOVED;
						ev_target <= hftm_pkg::TGT_W'(spare_idx);
					end else begin
						ev_code   <= hftm_pkg::EV_FAIL_NOSPARE;
						ev_target <= hftm_pkg::NO_NODE;
					end
				end else begin
					ev_code   <= hftm_pkg::EV_FAIL_IDLE;
					ev_task   <= hftm_pkg::NO_TASK;
					ev_target <= hftm_pkg::NO_NODE;
				end
			end

			// an overloaded node owning no task keeps its latch clear
			if (cmd.ovl_step && ovl_hit && own_ok) begin
				latch_q[idx_q] <= 1'b1;
				ev_valid <= 1'b1;
				ev_node  <= idx_q;
				ev_task  <= own_task;
				ev_last  <= 1'b0;
				if (spare_ok) begin
					ntask_q[idx_q]     <= hftm_pkg::NO_TASK;
					ntask_q[spare_idx] <= own_task;
					owner_q[own_task]  <= hftm_pkg::TGT_W'(spare_idx);
					ev_code   <= hftm_pkg::EV_OVL_MOVED;
					ev_target <= hftm_pkg::TGT_W'(spare_idx);
				end else begin
					ev_code   <= hftm_pkg::EV_OVL_NOSPARE;
					ev_target <= hftm_pkg::NO_NODE;
				end
			end

			if (cmd.emit_done) begin
				ev_valid  <= 1'b1;
				ev_code   <= hftm_pkg::EV_DONE;
				ev_node   <= '0;
				ev_task   <= hftm_pkg::NO_TASK;
				ev_target <= hftm_pkg::NO_NODE;
				ev_last   <= 1'b1;
			end
		end
	end

endmodule

[hw/rtl/heartbeat_failover_task_manager_top.sv]
// Top level of the heartbeat failover task manager: APB registers, sequencer, datapath.
// Depends on hftm_pkg, hftm_ctrl, hftm_dp and the macros header.
//
//   channel   handshake                         word
//   -------   -------------------------------   --------------------------------------
//   item      start & !busy                     req_type, node_id, cpu_load
//   event     event_valid (one cycle)           event_code, event_node, event_task,
//                                               target_node, last_of_run
//   config    psel & penable & pwrite           paddr[2] selects register, pwdata
//
// An item runs from accept to the closing word through the update state, the failure pass
// over every node, the overload pass over every node, the done state and the event word
// register. busy stays high until the closing word goes out.
// Every event word shows for one cycle; the receiver cannot stall.
// Reset sets the node table and task map to their defaults at once; no clearing pass.
`include "heartbeat_failover_task_manager_top_macros.svh"

module heartbeat_failover_task_manager_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          req_type,
	input  logic [hftm_pkg::NODE_W-1:0]   node_id,
	input  logic [hftm_pkg::LOAD_W-1:0]   cpu_load,
	output logic                          event_valid,
	output logic [2:0]                    event_code,
	output logic [hftm_pkg::NODE_W-1:0]   event_node,
	output logic [hftm_pkg::TASK_W-1:0]   event_task,
	output logic [hftm_pkg::TGT_W-1:0]    target_node,
	output logic                          last_of_run,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [2:0]                    paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);

	logic [hftm_pkg::AGE_W-1:0]  timeout_q;
	logic [hftm_pkg::LOAD_W-1:0] threshold_q;
	hftm_pkg::hftm_reg_t         reg_sel;
	hftm_pkg::hftm_cmd_t         cmd;
	hftm_pkg::hftm_stat_t        stat;
	hftm_pkg::hftm_event_t       ev_code;

	assign reg_sel = hftm_pkg::hftm_reg_t'(paddr[2]);
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q   <= hftm_pkg::TIMEOUT_RST;
			threshold_q <= hftm_pkg::THRESHOLD_RST;
		end else if (psel && penable && pwrite) begin
			unique case (reg_sel)
				hftm_pkg::REG_TIMEOUT:   timeout_q   <= pwdata[hftm_pkg::AGE_W-1:0];
				hftm_pkg::REG_THRESHOLD: threshold_q <= pwdata[hftm_pkg::LOAD_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			hftm_pkg::REG_TIMEOUT:   prdata = 32'(timeout_q);
			hftm_pkg::REG_THRESHOLD: prdata = 32'(threshold_q);
			default:                 prdata = '0;
		endcase
	end

	hftm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.stat   (stat)
	);

	hftm_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.req_type  (req_type),
		.node_id   (node_id),
		.cpu_load  (cpu_load),
		.timeout   (timeout_q),
		.threshold (threshold_q),
		.ev_valid  (event_valid),
		.ev_code   (ev_code),
		.ev_node   (event_node),
		.ev_task   (event_task),
		.ev_target (target_node),
		.ev_last   (last_of_run)
	);

	assign event_code = ev_code;

	`HFTM_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")
	`HFTM_ASSERT_IMPL(a_mid_word_busy, event_valid && !last_of_run, busy,
		"event word outside an item")
	`HFTM_ASSERT_IMPL(a_done_last, event_valid && (ev_code == hftm_pkg::EV_DONE),
		last_of_run, "step done word without last flag")
	`HFTM_ASSERT_IMPL(a_move_target,
		event_valid && (ev_code == hftm_pkg::EV_FAIL_MOVED || ev_code == hftm_pkg::EV_OVL_MOVED),
		target_node != hftm_pkg::NO_NODE, "moved task without a target node")

endmodule
